@@ src/assert_macros.svh @@
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/lk3_pkg.sv @@
// shared types and constants of the lookup3 byte stream hash
package lk3_pkg;

    localparam logic [31:0] HASH_GOLDEN    = 32'hdeadbeef;
    localparam logic [31:0] SEED_RESET     = 32'd12345;
    localparam int          GROUP_BYTES    = 12;
    localparam int          BUCKET_W       = 10;
    localparam int          TABLE_SIZE_DEF = 1024;
    localparam int          CMD_DEPTH_DEF  = 4;
    localparam int          RES_DEPTH_DEF  = 4;

    // one unit of work for the hash core: seed, add a gathered group, then mix, final or emit
    typedef struct packed {
        logic        seed_en;
        logic [31:0] init;
        logic        add_en;
        logic [31:0] add_a;
        logic [31:0] add_b;
        logic [31:0] add_c;
        logic        mix_en;
        logic        fin_en;
        logic        emit_en;
    } lk3_cmd_t;

    typedef struct packed {
        logic [31:0]         hash;
        logic [BUCKET_W-1:0] bucket;
    } lk3_res_t;

endpackage

@@ src/lk3_fifo.sv @@
// small register queue with show-ahead read
module lk3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ src/lk3_front.sv @@
// input side: byte gathering into 12-byte groups and command building
module lk3_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         key_byte,
    input  logic [15:0]        key_length,
    input  logic               first,
    input  logic               last,
    input  logic               seed_we,
    input  logic [31:0]        seed_data,
    output logic               cmd_push,
    output lk3_pkg::lk3_cmd_t  cmd,
    input  logic               cmd_full
);

    logic [31:0] seed_reg;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [95:0] grp_reg;
    logic [95:0] grp_next;
    logic        accept;
    logic        carries;
    logic [3:0]  pos_eff;
    logic [95:0] grp_with;
    logic        group_done;

    assign full    = cmd_full;
    assign accept  = push && !cmd_full;
    // a first beat with zero length carries no byte
    assign carries = !first || (key_length != 16'd0);
    assign pos_eff = first ? 4'd0 : pos_reg;
    assign grp_with = (first ? 96'd0 : grp_reg) | (96'(key_byte) << {pos_eff, 3'b000});
    assign group_done = carries && ((pos_eff == 4'(lk3_pkg::GROUP_BYTES - 1)) || last);

    always_comb
    begin
        cmd.seed_en = first;
        cmd.init    = lk3_pkg::HASH_GOLDEN + {14'd0, key_length, 2'b00} + seed_reg;
        cmd.add_en  = group_done;
        cmd.add_a   = grp_with[31:0];
        cmd.add_b   = grp_with[63:32];
        cmd.add_c   = grp_with[95:64];
        // a full group that is not the end is mixed right away; a later first reseeds anyway
        cmd.mix_en  = group_done && !last;
        cmd.fin_en  = group_done && last;
        cmd.emit_en = last;
        cmd_push    = accept && (first || group_done);
    end

    always_comb
    begin
        pos_next = pos_reg;
        grp_next = grp_reg;
        if (accept)
        begin
            if (!carries || group_done)
            begin
                pos_next = 4'd0;
                grp_next = '0;
            end
            else
            begin
                pos_next = pos_eff + 4'd1;
                grp_next = grp_with;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= lk3_pkg::SEED_RESET;
            pos_reg  <= '0;
            grp_reg  <= '0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
            pos_reg <= pos_next;
            grp_reg <= grp_next;
        end
    end

endmodule

@@ src/lk3_back.sv @@
// hash core: holds a, b, c and runs seed/add, mix and final one round per cycle
module lk3_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_empty,
    input  lk3_pkg::lk3_cmd_t  cmd,
    output logic               cmd_pop,
    output logic               res_valid,
    output logic [31:0]        res_hash,
    input  logic               res_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [2:0] MIX_LAST = 3'd5;
    localparam logic [2:0] FIN_LAST = 3'd6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic words_t mix_round(input words_t w, input logic [2:0] k);
        words_t r;
        r = w;
        case (k)
            3'd0:
            begin
                r.a = (w.a - w.c) ^ rotl(w.c, 4);
                r.c = w.c + w.b;
            end
            3'd1:
            begin
                r.b = (w.b - w.a) ^ rotl(w.a, 6);
                r.a = w.a + w.c;
            end
            3'd2:
            begin
                r.c = (w.c - w.b) ^ rotl(w.b, 8);
                r.b = w.b + w.a;
            end
            3'd3:
            begin
                r.a = (w.a - w.c) ^ rotl(w.c, 16);
                r.c = w.c + w.b;
            end
            3'd4:
            begin
                r.b = (w.b - w.a) ^ rotl(w.a, 19);
                r.a = w.a + w.c;
            end
            3'd5:
            begin
                r.c = (w.c - w.b) ^ rotl(w.b, 4);
                r.b = w.b + w.a;
            end
            default:
            begin
                r = w;
            end
        endcase
        return r;
    endfunction

    function automatic words_t fin_round(input words_t w, input logic [2:0] k);
        words_t r;
        r = w;
        case (k)
            3'd0: r.c = (w.c ^ w.b) - rotl(w.b, 14);
            3'd1: r.a = (w.a ^ w.c) - rotl(w.c, 11);
            3'd2: r.b = (w.b ^ w.a) - rotl(w.a, 25);
            3'd3: r.c = (w.c ^ w.b) - rotl(w.b, 16);
            3'd4: r.a = (w.a ^ w.c) - rotl(w.c, 4);
            3'd5: r.b = (w.b ^ w.a) - rotl(w.a, 14);
            3'd6: r.c = (w.c ^ w.b) - rotl(w.b, 24);
            default: r = w;
        endcase
        return r;
    endfunction

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    words_t     words_reg;
    words_t     words_next;

    assign res_valid = (state_reg == ST_EMIT);
    assign res_hash  = words_reg.c;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        words_next = words_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop      = 1'b1;
                    words_next.a = (cmd.seed_en ? cmd.init : words_reg.a)
                                 + (cmd.add_en ? cmd.add_a : 32'd0);
                    words_next.b = (cmd.seed_en ? cmd.init : words_reg.b)
                                 + (cmd.add_en ? cmd.add_b : 32'd0);
                    words_next.c = (cmd.seed_en ? cmd.init : words_reg.c)
                                 + (cmd.add_en ? cmd.add_c : 32'd0);
                    step_next    = 3'd0;
                    if (cmd.mix_en)
                    begin
                        state_next = ST_MIX;
                    end
                    else if (cmd.fin_en)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (cmd.emit_en)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MIX:
            begin
                words_next = mix_round(words_reg, step_reg);
                step_next  = step_reg + 3'd1;
                if (step_reg == MIX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                words_next = fin_round(words_reg, step_reg);
                step_next  = step_reg + 3'd1;
                if (step_reg == FIN_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            words_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            words_reg <= words_next;
        end
    end

endmodule

@@ src/lk3_bucket.sv @@
// hash modulo table size: reciprocal multiply, back-multiply, two corrections
module lk3_bucket #(
    parameter int TABLE_SIZE = lk3_pkg::TABLE_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       in_hash,
    output logic              in_ready,
    output logic              res_push,
    output lk3_pkg::lk3_res_t res,
    input  logic              res_full
);

    localparam logic [63:0] RECIP_W = 64'hffff_ffff / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];
    localparam int          TS_W    = $clog2(TABLE_SIZE + 1);
    localparam logic [TS_W-1:0] TS  = TS_W'(TABLE_SIZE);
    // the estimated quotient is at most two short, so the remainder stays below 3x
    localparam int          RW      = $clog2(3 * TABLE_SIZE);
    localparam logic [RW-1:0] TS_R  = RW'(TABLE_SIZE);

    logic [4:0]       v_reg;
    logic             adv;
    logic [31:0]      h1_reg;
    logic [63:0]      p1_reg;
    logic [31:0]      h2_reg;
    logic [31:0]      qt2_reg;
    logic [31:0]      h3_reg;
    logic [RW-1:0]    r3_reg;
    logic [31:0]      h4_reg;
    logic [RW-1:0]    r4_reg;
    logic [31:0]      h5_reg;
    logic [RW-1:0]    r5_reg;
    logic [31+TS_W:0] qt_full;

    // whole pipe holds while the last stage cannot leave
    assign adv      = !(v_reg[4] && res_full);
    assign in_ready = adv;
    assign res_push = v_reg[4] && !res_full;
    assign res.hash   = h5_reg;
    assign res.bucket = lk3_pkg::BUCKET_W'(r5_reg);
    assign qt_full  = p1_reg[63:32] * TS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_reg  <= in_hash;
            p1_reg  <= in_hash * RECIP;
            h2_reg  <= h1_reg;
            qt2_reg <= qt_full[31:0];
            h3_reg  <= h2_reg;
            r3_reg  <= RW'(h2_reg - qt2_reg);
            h4_reg  <= h3_reg;
            r4_reg  <= (r3_reg >= TS_R) ? r3_reg - TS_R : r3_reg;
            h5_reg  <= h4_reg;
            r5_reg  <= (r4_reg >= TS_R) ? r4_reg - TS_R : r4_reg;
        end
    end

endmodule

@@ src/lookup3_byte_stream_hash_top.sv @@
// top level of the lookup3 byte stream hash
//
//  channel   direction  handshake            payload
//  input     in         push / full          key_byte, key_length, first, last
//  result    out        empty / pop          hash, bucket
//  seed      in         seed_we (no wait)    seed_data
//
// one input beat is taken per cycle while the command queue has room, and a long key
// runs at one byte per cycle; the hash core takes one command at a time and runs the
// mix rounds of a full group or the final rounds, and holds the hash for the bucket pipe,
// which takes a new hash every cycle unless a full result queue holds it; reset clears
// the hash words, queues and pipe and sets the seed to 12345; no clearing pass
module lookup3_byte_stream_hash_top #(
    parameter int TABLE_SIZE = lk3_pkg::TABLE_SIZE_DEF,
    parameter int CMD_DEPTH  = lk3_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = lk3_pkg::RES_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   key_byte,
    input  logic [15:0]                  key_length,
    input  logic                         first,
    input  logic                         last,
    output logic                         empty,
    input  logic                         pop,
    output logic [31:0]                  hash,
    output logic [lk3_pkg::BUCKET_W-1:0] bucket,
    input  logic                         seed_we,
    input  logic [31:0]                  seed_data
);

    localparam int CMD_W = $bits(lk3_pkg::lk3_cmd_t);
    localparam int RES_W = $bits(lk3_pkg::lk3_res_t);

    logic              cmd_push;
    lk3_pkg::lk3_cmd_t cmd_w;
    logic              cmd_full;
    logic              cmd_pop;
    logic [CMD_W-1:0]  cmd_rdata;
    lk3_pkg::lk3_cmd_t cmd_r;
    logic              cmd_empty;
    logic              hash_valid;
    logic [31:0]       hash_w;
    logic              hash_ready;
    logic              res_push;
    lk3_pkg::lk3_res_t res_w;
    logic              res_full;
    logic [RES_W-1:0]  res_rdata;
    lk3_pkg::lk3_res_t res_r;

    assign cmd_r  = lk3_pkg::lk3_cmd_t'(cmd_rdata);
    assign res_r  = lk3_pkg::lk3_res_t'(res_rdata);
    assign hash   = res_r.hash;
    assign bucket = res_r.bucket;

    lk3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .key_byte   (key_byte),
        .key_length (key_length),
        .first      (first),
        .last       (last),
        .seed_we    (seed_we),
        .seed_data  (seed_data),
        .cmd_push   (cmd_push),
        .cmd        (cmd_w),
        .cmd_full   (cmd_full)
    );

    lk3_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_w),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    lk3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_r),
        .cmd_pop   (cmd_pop),
        .res_valid (hash_valid),
        .res_hash  (hash_w),
        .res_ready (hash_ready)
    );

    lk3_bucket #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_bucket (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (hash_valid),
        .in_hash  (hash_w),
        .in_ready (hash_ready),
        .res_push (res_push),
        .res      (res_w),
        .res_full (res_full)
    );

    lk3_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_w),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

`include "assert_macros.svh"

    // a command is only built for an accepted beat
    `ASSERT_IMPL(a_cmd_no_overflow, clk, rst_n, cmd_push, !cmd_full)
    // a first beat always leaves work queued for the core
    `ASSERT_NEXT(a_first_queued, clk, rst_n, push && !full && first, !cmd_empty)
    // final always ends in a result and never comes with a mix
    `ASSERT_IMPL(a_fin_emits, clk, rst_n, cmd_push && cmd_w.fin_en,
                 cmd_w.emit_en && cmd_w.add_en && !cmd_w.mix_en)
    // the bucket pipe never drops a result into a full queue
    `ASSERT_IMPL(a_res_no_overflow, clk, rst_n, res_push, !res_full)

endmodule

@@ bench/lookup3_byte_stream_hash_top_test.sv @@
// byte stream lookup3 hash testbench: directed edge keys, then random keys against a predictor
module lookup3_byte_stream_hash_top_test;

    localparam int TABLE_SIZE    = lk3_pkg::TABLE_SIZE_DEF;
    // time for a key to pass the core, the bucket pipe and both queues
    localparam int SETTLE_CYCLES = 40;

    typedef enum int {
        POP_ALWAYS,
        POP_COIN,
        POP_PATTERN,
        POP_SPARSE
    } pop_mode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [7:0]  key_byte   = 8'd0;
    logic [15:0] key_length = 16'd0;
    logic        first      = 1'b0;
    logic        last       = 1'b0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [31:0] hash;
    logic [lk3_pkg::BUCKET_W-1:0] bucket;
    logic        seed_we    = 1'b0;
    logic [31:0] seed_data  = 32'd0;

    // predicted hash state
    logic [31:0] st_a;
    logic [31:0] st_b;
    logic [31:0] st_c;
    int          byte_slot;
    bit          mix_owed;
    logic [31:0] seed_now;

    lk3_pkg::lk3_res_t hash_due[$];
    int          errors     = 0;
    int          beats_sent = 0;

    // sender and receiver pacing
    bit          idle_on    = 1'b0;
    int          burst_left = 0;
    pop_mode_t   pop_mode   = POP_COIN;
    logic [12:0] pop_pat    = 13'b1011001110100;

    lookup3_byte_stream_hash_top #(
        .TABLE_SIZE(TABLE_SIZE)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .key_byte  (key_byte),
        .key_length(key_length),
        .first     (first),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .hash      (hash),
        .bucket    (bucket),
        .seed_we   (seed_we),
        .seed_data (seed_data)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] rot_left(logic [31:0] x, int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic void stir_words();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = st_a;
        b = st_b;
        c = st_c;
        a -= c; a ^= rot_left(c, 4);  c += b;
        b -= a; b ^= rot_left(a, 6);  a += c;
        c -= b; c ^= rot_left(b, 8);  b += a;
        a -= c; a ^= rot_left(c, 16); c += b;
        b -= a; b ^= rot_left(a, 19); a += c;
        c -= b; c ^= rot_left(b, 4);  b += a;
        st_a = a;
        st_b = b;
        st_c = c;
    endfunction

    function automatic void finish_words();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = st_a;
        b = st_b;
        c = st_c;
        c ^= b; c -= rot_left(b, 14);
        a ^= c; a -= rot_left(c, 11);
        b ^= a; b -= rot_left(a, 25);
        c ^= b; c -= rot_left(b, 16);
        a ^= c; a -= rot_left(c, 4);
        b ^= a; b -= rot_left(a, 14);
        c ^= b; c -= rot_left(b, 24);
        st_a = a;
        st_b = b;
        st_c = c;
    endfunction

    function automatic void predict_beat(logic [7:0] kb, logic [15:0] kl, logic kf, logic kz);
        logic [31:0] init;
        logic [31:0] addend;
        bit          carries;
        lk3_pkg::lk3_res_t res;
        carries = 1'b1;
        if (kf)
        begin
            init      = lk3_pkg::HASH_GOLDEN + (32'(kl) << 2) + seed_now;
            st_a      = init;
            st_b      = init;
            st_c      = init;
            byte_slot = 0;
            mix_owed  = 1'b0;
            if (kl == 16'd0)
                carries = 1'b0;
        end
        if (carries)
        begin
            // a full group is only mixed once another byte shows up
            if (mix_owed)
            begin
                stir_words();
                mix_owed = 1'b0;
            end
            addend = 32'(kb) << (8 * (byte_slot % 4));
            if (byte_slot < 4)
                st_a += addend;
            else if (byte_slot < 8)
                st_b += addend;
            else
                st_c += addend;
            byte_slot++;
            if (byte_slot == lk3_pkg::GROUP_BYTES)
            begin
                byte_slot = 0;
                mix_owed  = 1'b1;
            end
        end
        if (kz)
        begin
            // nothing gathered since the seed: c goes out unmixed
            if (byte_slot != 0 || mix_owed)
            begin
                finish_words();
                byte_slot = 0;
                mix_owed  = 1'b0;
            end
            res.hash   = st_c;
            res.bucket = lk3_pkg::BUCKET_W'(st_c % TABLE_SIZE);
            hash_due.push_back(res);
        end
    endfunction

    // called right after a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input logic [7:0] kb, input logic [15:0] kl, input logic kf,
                             input logic kz);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            gap  = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        push       <= 1'b1;
        key_byte   <= kb;
        key_length <= kl;
        first      <= kf;
        last       <= kz;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        predict_beat(kb, kl, kf, kz);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // nbytes key bytes; with with_first set, a first beat leads if the length or nbytes is zero
    task automatic send_key(input logic [15:0] kl, input int nbytes, input bit with_first,
                            input bit with_last);
        if (with_first && (kl == 16'd0 || nbytes == 0))
        begin
            send_beat(8'($urandom), kl, 1'b1, with_last && nbytes == 0);
            with_first = 1'b0;
        end
        for (int i = 0; i < nbytes; i++)
            send_beat(8'($urandom), kl, with_first && i == 0, with_last && i == nbytes - 1);
    endtask

    function automatic int pick_length();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return 0;
            1:       return lk3_pkg::GROUP_BYTES * $urandom_range(1, 3);
            2:       return lk3_pkg::GROUP_BYTES * $urandom_range(1, 3) + 1;
            3:       return $urandom_range(40, 100);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic drain();
        push <= 1'b0;
        while (hash_due.size() != 0)
            @(posedge clk);
        // a key without last may still be in the core
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_seed(input logic [31:0] v);
        drain();
        seed_we   <= 1'b1;
        seed_data <= v;
        @(posedge clk);
        seed_we  <= 1'b0;
        seed_now  = v;
    endtask

    task automatic run_random_keys(input int count, input int noise_pct);
        int stop_at;
        int len;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(0, 99) >= noise_pct)
            begin
                len = pick_length();
                send_key(16'(len), len, 1'b1, 1'b1);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    // length field disagrees with the bytes delivered
                    0: send_key(16'($urandom), $urandom_range(1, 30), 1'b1, 1'b1);
                    // key abandoned before last, next first reseeds
                    1:
                    begin
                        len = $urandom_range(2, 30);
                        send_key(16'(len), $urandom_range(1, len - 1), 1'b1, 1'b0);
                    end
                    // stray bytes after a finished key
                    2: send_key(16'd0, $urandom_range(1, 4), 1'b0, 1'($urandom_range(0, 1)));
                    // empty first beat that is not last, bytes follow
                    default: send_key(16'd0, $urandom_range(1, 14), 1'b1, 1'b1);
                endcase
            end
        end
    endtask

    // no first since reset: bytes land in the zero state, then more without first
    task automatic test_unseeded_stream();
        send_beat(8'hff, 16'hffff, 1'b0, 1'b0);
        send_beat(8'h00, 16'h0000, 1'b0, 1'b1);
        send_beat(8'h5a, 16'h0000, 1'b0, 1'b1);
    endtask

    task automatic test_special_keys();
        // empty key
        send_beat(8'h3c, 16'd0, 1'b1, 1'b1);
        // empty first beat, then one byte
        send_beat(8'h77, 16'd0, 1'b1, 1'b0);
        send_beat(8'h81, 16'd0, 1'b0, 1'b1);
        // widest length field over a one byte key
        send_beat(8'hff, 16'hffff, 1'b1, 1'b1);
        // new first in the middle of a key
        send_beat(8'h00, 16'd3, 1'b1, 1'b0);
        send_beat(8'h80, 16'd3, 1'b0, 1'b0);
        send_beat(8'h01, 16'd2, 1'b1, 1'b0);
        send_beat(8'hfe, 16'd2, 1'b0, 1'b1);
    endtask

    // a 13-byte key: one full group that is mixed, then one byte that goes into the final
    task automatic test_group_boundary();
        for (int i = 0; i < lk3_pkg::GROUP_BYTES + 1; i++)
            send_beat((i % 2 == 0) ? 8'hff : 8'h00, 16'd13, i == 0, i == lk3_pkg::GROUP_BYTES);
    endtask

    task automatic test_bursty_keys();
        set_seed(32'd0);
        idle_on  = 1'b1;
        pop_mode = POP_COIN;
        run_random_keys(180, 10);
    endtask

    task automatic test_streaming_keys();
        set_seed(32'hffffffff);
        idle_on  = 1'b0;
        pop_mode = POP_ALWAYS;
        run_random_keys(150, 10);
    endtask

    task automatic test_slow_receiver();
        set_seed($urandom);
        idle_on  = 1'b1;
        pop_mode = POP_SPARSE;
        run_random_keys(150, 10);
    endtask

    task automatic test_broken_streams();
        set_seed($urandom);
        idle_on  = 1'b1;
        pop_mode = POP_PATTERN;
        run_random_keys(170, 35);
    endtask

    always @(posedge clk)
    begin
        case (pop_mode)
            POP_ALWAYS:  pop <= 1'b1;
            POP_COIN:    pop <= 1'($urandom_range(0, 1));
            POP_PATTERN:
            begin
                pop_pat <= {pop_pat[11:0], pop_pat[12]};
                pop     <= pop_pat[0];
            end
            default:     pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // outputs settle between edges; a beat is taken at the next rising edge
    always @(negedge clk)
    begin : check_beat
        lk3_pkg::lk3_res_t want;
        if (rst_n && pop && !empty)
        begin
            if (hash_due.size() == 0)
            begin
                $display("%0t: unexpected result hash %h bucket %h", $time, hash, bucket);
                errors++;
            end
            else
            begin
                want = hash_due.pop_front();
                if (hash !== want.hash)
                begin
                    $display("%0t: hash expected %h actual %h", $time, want.hash, hash);
                    errors++;
                end
                if (bucket !== want.bucket)
                begin
                    $display("%0t: bucket expected %h actual %h", $time, want.bucket, bucket);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        st_a      = 32'd0;
        st_b      = 32'd0;
        st_c      = 32'd0;
        byte_slot = 0;
        mix_owed  = 1'b0;
        seed_now  = lk3_pkg::SEED_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unseeded_stream();
        test_special_keys();
        test_group_boundary();
        test_bursty_keys();
        test_streaming_keys();
        test_slow_receiver();
        test_broken_streams();
        drain();
        if (errors == 0)
            $display("lookup3_byte_stream_hash_top_test OK");
        else
            $display("lookup3_byte_stream_hash_top_test NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("lookup3_byte_stream_hash_top_test NOT OK");
        $finish;
    end

endmodule
